### src/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

  localparam int CP_W          = 21;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [7:0]      BOM_LEAD     = 8'hEF;
  localparam logic [7:0]      LEAD_INVALID = 8'hF8;
  localparam logic [CP_W-1:0] BOM_CP       = 21'h00FEFF;
  localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_BMP_MAX   = 21'h00FFFF;
  localparam logic [CP_W-1:0] SUPP_BASE    = 21'h010000;
  localparam logic [15:0]     HI_SURR_BASE = 16'hD800;
  localparam logic [15:0]     LO_SURR_BASE = 16'hDC00;
  localparam logic [9:0]      SURR_MASK    = 10'h3FF;
  localparam logic [5:0]      CONT_MASK    = 6'h3F;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        error_flag;
    logic        string_done;
  } out_item_t;

  // one decoded request between front and back
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            is_unit;
    logic            is_pair;
    logic            err;
    logic            done;
  } q_entry_t;

endpackage

`default_nettype wire

### src/u8u16_front.sv
// ----------------------------------------------------------------------------
// u8u16_front
// Byte classifier and code point accumulator; writes one request per
// decoded code point or string end into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_front
  import u8u16_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     acc_en,
  input  wire in_item_t in_data,
  output logic          q_push,
  output q_entry_t      q_data
);

  logic [CP_W-1:0] accum_r, accum_nxt;
  logic [1:0]      pend_r, pend_nxt;
  logic            start_r, start_nxt;
  logic            bom_cand_r, bom_cand_nxt;
  logic            err_r, err_nxt;

  // A completed code point can only be a byte-order mark when it closes a
  // sequence opened by 0xEF as the string's first byte; an ASCII byte has
  // no such lead.
  function automatic logic bom_cand_nxt_src(input logic cand, input logic [1:0] pend);
    bom_cand_nxt_src = cand && (pend != 2'd0);
  endfunction

  always_comb begin
    logic [7:0]      b;
    logic            err;
    logic            complete;
    logic            unit;
    logic [CP_W-1:0] cp;

    b            = in_data.in_byte;
    err          = err_r;
    complete     = 1'b0;
    unit         = 1'b0;
    cp           = '0;
    accum_nxt    = accum_r;
    pend_nxt     = pend_r;
    start_nxt    = start_r;
    bom_cand_nxt = bom_cand_r;
    err_nxt      = err_r;

    if (!err_r) begin
      if (pend_r == 2'd0) begin
        if (!b[7]) begin
          cp           = {13'd0, b};
          complete     = 1'b1;
          bom_cand_nxt = 1'b0;
        end else if (b[7:6] == 2'b10 || b >= LEAD_INVALID) begin
          err = 1'b1;
        end else begin
          if (b[5] == 1'b0) begin
            accum_nxt = {16'd0, b[4:0]};
            pend_nxt  = 2'd1;
          end else if (b[4] == 1'b0) begin
            accum_nxt = {17'd0, b[3:0]};
            pend_nxt  = 2'd2;
          end else begin
            accum_nxt = {18'd0, b[2:0]};
            pend_nxt  = 2'd3;
          end
          bom_cand_nxt = start_r && (b == BOM_LEAD);
        end
      end else if (b[7:6] != 2'b10) begin
        err = 1'b1;
      end else begin
        accum_nxt = {accum_r[CP_W-7:0], b[5:0] & CONT_MASK};
        pend_nxt  = pend_r - 2'd1;
        if (pend_r == 2'd1) begin
          cp       = accum_nxt;
          complete = 1'b1;
        end
      end

      if (complete) begin
        accum_nxt    = '0;
        bom_cand_nxt = 1'b0;
        if (cp > CP_MAX) begin
          err = 1'b1;
        end else if (!(bom_cand_nxt_src(bom_cand_r, pend_r) && cp == BOM_CP)) begin
          unit = 1'b1;
        end
      end
      if (err) begin
        accum_nxt    = '0;
        pend_nxt     = 2'd0;
        bom_cand_nxt = 1'b0;
      end
    end
    start_nxt = 1'b0;

    q_data.code_point = cp;
    q_data.is_unit    = unit;
    q_data.is_pair    = unit && (cp > CP_BMP_MAX);
    q_data.done       = in_data.end_of_string;

    if (in_data.end_of_string) begin
      if (!err && pend_nxt != 2'd0) begin
        err = 1'b1;
      end
      accum_nxt    = '0;
      pend_nxt     = 2'd0;
      start_nxt    = 1'b1;
      bom_cand_nxt = 1'b0;
      err_nxt      = 1'b0;
    end else begin
      err_nxt = err;
    end

    q_data.err = err && !unit;
    q_push     = acc_en && (unit || in_data.end_of_string);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r    <= '0;
      pend_r     <= 2'd0;
      start_r    <= 1'b1;
      bom_cand_r <= 1'b0;
      err_r      <= 1'b0;
    end else if (acc_en) begin
      accum_r    <= accum_nxt;
      pend_r     <= pend_nxt;
      start_r    <= start_nxt;
      bom_cand_r <= bom_cand_nxt;
      err_r      <= err_nxt;
    end
  end

endmodule

`default_nettype wire

### src/u8u16_fifo.sv
// ----------------------------------------------------------------------------
// u8u16_fifo
// Short request queue between the front classifier and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_fifo
  import u8u16_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr_en,
  input  wire q_entry_t wr_data,
  output logic          full,
  input  wire logic     rd_en,
  output q_entry_t      rd_data,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### src/u8u16_back.sv
// ----------------------------------------------------------------------------
// u8u16_back
// Turns queued requests into UTF-16 results; a supplementary code point
// is split into a high and a low surrogate over two output slots.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_back
  import u8u16_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire q_entry_t q_data,
  input  wire logic     q_empty,
  output logic          q_pop,
  output out_item_t     out_data,
  output logic          out_empty,
  input  wire logic     out_pop
);

  out_item_t       out_r, out_nxt;
  logic            vld_r;
  logic            phase_r, phase_nxt;
  logic            load_en;
  logic [CP_W-1:0] supp;

  assign load_en   = !vld_r || out_pop;
  assign supp      = q_data.code_point - SUPP_BASE;
  assign out_data  = out_r;
  assign out_empty = !vld_r;

  function automatic logic q_is_idle();
    q_is_idle = q_empty || !load_en;
  endfunction

  always_comb begin
    out_nxt   = out_r;
    phase_nxt = phase_r;
    q_pop     = 1'b0;
    if (!q_is_idle()) begin
      out_nxt.unit_valid = q_data.is_unit;
      out_nxt.error_flag = q_data.err;
      if (!q_data.is_unit) begin
        out_nxt.code_unit   = '0;
        out_nxt.string_done = q_data.done;
        q_pop               = 1'b1;
      end else if (!q_data.is_pair) begin
        out_nxt.code_unit   = q_data.code_point[15:0];
        out_nxt.string_done = q_data.done;
        q_pop               = 1'b1;
      end else if (!phase_r) begin
        out_nxt.code_unit   = HI_SURR_BASE | {6'd0, supp[19:10]};
        out_nxt.string_done = 1'b0;
        phase_nxt           = 1'b1;
      end else begin
        out_nxt.code_unit   = LO_SURR_BASE | {6'd0, supp[9:0] & SURR_MASK};
        out_nxt.string_done = q_data.done;
        phase_nxt           = 1'b0;
        q_pop               = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (load_en) begin
        vld_r <= !q_empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire

### src/utf8_to_utf16_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Path: with queue and output idle, a byte's result reaches the out_ ports
// through the request queue (front writes it) and the back's output register.
// Throughput: one byte per cycle while the queue is not full; a surrogate pair
// takes two output slots, absorbed by the request queue between front and back.
// Reset: synchronous, active low; clears decode state, queue and output.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_decoder
  import u8u16_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  input  wire in_item_t in_data,
  output logic          in_full,
  output out_item_t     out_data,
  output logic          out_empty,
  input  wire logic     out_pop
);

  logic     acc_en;
  logic     q_push, q_pop, q_full, q_empty;
  q_entry_t q_wdata, q_rdata;

  assign in_full = q_full;
  assign acc_en  = in_push && !q_full;

  u8u16_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc_en (acc_en),
    .in_data(in_data),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  u8u16_fifo #(
    .DEPTH(QDEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_push),
    .wr_data(q_wdata),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_data(q_rdata),
    .empty  (q_empty)
  );

  u8u16_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_data   (q_rdata),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_data (out_data),
    .out_empty(out_empty),
    .out_pop  (out_pop)
  );

  a_unit_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.unit_valid) |-> !out_data.error_flag)
    else $error("unit result carries error flag");

  a_nounit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.unit_valid) |-> out_data.string_done)
    else $error("empty result not marked as string end");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed before pop");

  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("queue both full and empty");

endmodule

`default_nettype wire

### sim/tb_utf8_to_utf16_decoder.sv
// ----------------------------------------------------------------------------
// tb_utf8_to_utf16_decoder
// Self-checking bench for the UTF-8 to UTF-16 decoder. A short directed table
// covers byte extremes, the byte-order mark and each error path. Random
// strings follow, mostly well formed, some broken, some noise. Every accepted
// byte is run through a local decoder model. Each popped unit is checked
// against the oldest expected unit. Sender bursts and receiver stalls are
// random, and one long output hold forces the input side to back up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_utf8_to_utf16_decoder;
  import u8u16_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    in_item_t  item;
    logic      typed;  // want holds a hand-written result
    out_item_t want;
  } stim_row_t;

  typedef enum logic [1:0] {CP_ASCII, CP_TWO, CP_THREE, CP_FOUR} cp_class_e;
  typedef enum logic [1:0] {DEF_TRUNC, DEF_BAD_CONT, DEF_RANGE, DEF_STRAY} defect_e;
  typedef enum logic [1:0] {POP_ALL, POP_COIN, POP_EVERY3, POP_SPARSE} pop_mode_e;

  localparam int DIR_N      = 24;
  localparam int RAND_BYTES = 900;
  localparam int HOLD_AT    = 250;  // results taken before the long hold
  localparam int HOLD_LEN   = 200;
  localparam int MAX_PRINTS = 40;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      in_push = 1'b0;
  in_item_t  in_data = '0;
  logic      in_full;
  out_item_t out_data;
  logic      out_empty;
  logic      out_pop = 1'b0;

  utf8_to_utf16_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .out_data (out_data),
    .out_empty(out_empty),
    .out_pop  (out_pop)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Decoder model state
  // --------------------------------------------------------------------------
  logic [20:0] acc_cp;
  logic [1:0]  cont_left;
  logic        fresh_string;
  logic        bom_lead_first;
  logic        string_bad;

  out_item_t   unit_q[$];
  stim_row_t   stim_q[$];
  stim_row_t   dir_tab[DIR_N];
  logic [7:0]  str_q[$];

  int n_errors     = 0;
  int n_bytes      = 0;
  int n_results    = 0;
  int n_units      = 0;
  int n_strings    = 0;
  int n_bad_str    = 0;
  int n_full_stall = 0;
  int n_rand       = 0;

  initial begin
    #1_000_000;
    $display("timeout: %0d units still expected", unit_q.size());
    $display("DONE: errors detected");
    $finish;
  end

  function automatic out_item_t mk_res(logic [15:0] code, logic valid, logic err, logic done);
    out_item_t r;
    r.code_unit   = code;
    r.unit_valid  = valid;
    r.error_flag  = err;
    r.string_done = done;
    return r;
  endfunction

  function automatic stim_row_t mk_row(logic [7:0] b, logic eos, logic typed, out_item_t want);
    stim_row_t r;
    r.item.in_byte       = b;
    r.item.end_of_string = eos;
    r.typed              = typed;
    r.want               = want;
    return r;
  endfunction

  function automatic void clear_decoder();
    acc_cp         = '0;
    cont_left      = '0;
    fresh_string   = 1'b1;
    bom_lead_first = 1'b0;
    string_bad     = 1'b0;
  endfunction

  // Decode one byte; returns the number of units it yields (0..2).
  function automatic int decode_byte(input in_item_t it, output out_item_t r0,
                                     output out_item_t r1);
    logic [7:0]  b;
    logic        eos;
    logic        err;
    logic        complete;
    logic        bom;
    logic [20:0] cp;
    logic [20:0] v;
    int          n;
    out_item_t   res[2];
    b        = it.in_byte;
    eos      = it.end_of_string;
    err      = string_bad;
    complete = 1'b0;
    cp       = '0;
    n        = 0;
    res[0]   = '0;
    res[1]   = '0;
    if (!err) begin
      if (cont_left == 2'd0) begin
        if (b < 8'h80) begin
          cp             = {13'd0, b};
          complete       = 1'b1;
          bom_lead_first = 1'b0;
        end else if (b < 8'hC0 || b >= 8'hF8) begin
          err = 1'b1;
        end else begin
          if (b < 8'hE0) begin
            acc_cp    = {16'd0, b[4:0]};
            cont_left = 2'd1;
          end else if (b < 8'hF0) begin
            acc_cp    = {17'd0, b[3:0]};
            cont_left = 2'd2;
          end else begin
            acc_cp    = {18'd0, b[2:0]};
            cont_left = 2'd3;
          end
          bom_lead_first = fresh_string && b == 8'hEF;
        end
      end else if (b[7:6] != 2'b10) begin
        err = 1'b1;
      end else begin
        acc_cp    = {acc_cp[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          cp       = acc_cp;
          complete = 1'b1;
        end
      end

      if (complete) begin
        bom            = bom_lead_first && cp == 21'h00FEFF;
        bom_lead_first = 1'b0;
        acc_cp         = '0;
        if (cp > 21'h10FFFF) begin
          err = 1'b1;
        end else if (!bom) begin
          if (cp > 21'h00FFFF) begin
            v        = cp - 21'h010000;
            res[n]   = mk_res(16'hD800 + {6'd0, v[19:10]}, 1'b1, 1'b0, 1'b0);
            n++;
            res[n]   = mk_res(16'hDC00 + {6'd0, v[9:0]}, 1'b1, 1'b0, 1'b0);
            n++;
          end else begin
            res[n] = mk_res(cp[15:0], 1'b1, 1'b0, 1'b0);
            n++;
          end
        end
      end
      if (err) begin
        acc_cp         = '0;
        cont_left      = '0;
        bom_lead_first = 1'b0;
      end
    end
    fresh_string = 1'b0;

    if (eos) begin
      if (!err && cont_left != 2'd0) err = 1'b1;
      if (n == 0) begin
        res[0] = mk_res(16'h0000, 1'b0, err, 1'b1);
        n      = 1;
      end else begin
        res[n-1].string_done = 1'b1;
      end
      clear_decoder();
    end else begin
      string_bad = err;
    end
    r0 = res[0];
    r1 = res[1];
    return n;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (n_errors < MAX_PRINTS)
      $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
    n_errors++;
  endtask

  // --------------------------------------------------------------------------
  // Random string builders
  // --------------------------------------------------------------------------
  task automatic add_cont();
    str_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
  endtask

  task automatic add_code_point();
    cp_class_e  cls;
    logic [7:0] lead;
    cls = cp_class_e'($urandom_range(0, 3));
    case (cls)
      CP_ASCII: str_q.push_back(8'($urandom_range(8'h00, 8'h7F)));
      CP_TWO: begin
        str_q.push_back(8'($urandom_range(8'hC0, 8'hDF)));
        add_cont();
      end
      CP_THREE: begin
        str_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
        add_cont();
        add_cont();
      end
      default: begin
        lead = 8'($urandom_range(8'hF0, 8'hF4));
        str_q.push_back(lead);
        // keep F4 sequences at or below U+10FFFF
        if (lead == 8'hF4) str_q.push_back(8'($urandom_range(8'h80, 8'h8F)));
        else add_cont();
        add_cont();
        add_cont();
      end
    endcase
  endtask

  task automatic add_defect(input defect_e d);
    logic [7:0] b;
    case (d)
      DEF_TRUNC: begin
        if ($urandom_range(0, 1) == 0) begin
          str_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
          repeat ($urandom_range(0, 1)) add_cont();
        end else begin
          str_q.push_back(8'($urandom_range(8'hF0, 8'hF7)));
          repeat ($urandom_range(0, 2)) add_cont();
        end
      end
      DEF_BAD_CONT: begin
        str_q.push_back(8'($urandom_range(8'hC2, 8'hF4)));
        b = 8'($urandom);
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        str_q.push_back(b);
      end
      DEF_RANGE: begin
        if ($urandom_range(0, 1) == 0) begin
          str_q.push_back(8'hF4);
          str_q.push_back(8'($urandom_range(8'h90, 8'hBF)));
        end else begin
          str_q.push_back(8'($urandom_range(8'hF5, 8'hF7)));
          add_cont();
        end
        add_cont();
        add_cont();
      end
      default: begin
        if ($urandom_range(0, 1) == 0) str_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
        else str_q.push_back(8'($urandom_range(8'hF8, 8'hFF)));
      end
    endcase
  endtask

  task automatic gen_string();
    int      kind;
    defect_e d;
    str_q.delete();
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      if ($urandom_range(0, 5) == 0) begin
        str_q.push_back(8'hEF);
        str_q.push_back(8'hBB);
        str_q.push_back(8'hBF);
      end
      repeat ($urandom_range(1, 6)) add_code_point();
    end else if (kind == 7) begin
      repeat ($urandom_range(0, 3)) add_code_point();
      d = defect_e'($urandom_range(0, 3));
      add_defect(d);
      if (d != DEF_TRUNC) repeat ($urandom_range(0, 3)) add_code_point();
    end else begin
      repeat ($urandom_range(1, 6)) str_q.push_back(8'($urandom));
    end
    foreach (str_q[i])
      stim_q.push_back(mk_row(str_q[i], i == str_q.size() - 1, 1'b0, '0));
    n_rand += str_q.size();
  endtask

  // --------------------------------------------------------------------------
  // Sender: bursts of requests with random gaps
  // --------------------------------------------------------------------------
  stim_row_t cur_row;
  out_item_t pr0, pr1;
  int        n_pred;
  int        burst_left = 0;
  int        gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (in_push && in_full) begin
      n_full_stall++;
    end else begin
      if (in_push) begin
        n_bytes++;
        n_pred = decode_byte(cur_row.item, pr0, pr1);
        if (cur_row.typed) begin
          unit_q.push_back(cur_row.want);
        end else begin
          if (n_pred > 0) unit_q.push_back(pr0);
          if (n_pred > 1) unit_q.push_back(pr1);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        in_push <= 1'b0;
      end else if (stim_q.size() > 0) begin
        cur_row = stim_q.pop_front();
        in_data <= cur_row.item;
        in_push <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: checks each popped unit, stalls on its own pattern
  // --------------------------------------------------------------------------
  out_item_t want_unit;
  pop_mode_e pop_mode  = POP_ALL;
  int        mode_left = 0;
  int        phase     = 0;
  int        hold_left = 0;
  logic      held      = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        n_results++;
        if (out_data.unit_valid) n_units++;
        if (out_data.string_done) begin
          n_strings++;
          if (out_data.error_flag) n_bad_str++;
        end
        if (unit_q.size() == 0) begin
          report_mismatch("unit with nothing expected", out_data.code_unit, 16'h0000);
        end else begin
          want_unit = unit_q.pop_front();
          if (out_data.code_unit !== want_unit.code_unit)
            report_mismatch("code_unit", out_data.code_unit, want_unit.code_unit);
          if (out_data.unit_valid !== want_unit.unit_valid)
            report_mismatch("unit_valid", out_data.unit_valid, want_unit.unit_valid);
          if (out_data.error_flag !== want_unit.error_flag)
            report_mismatch("error_flag", out_data.error_flag, want_unit.error_flag);
          if (out_data.string_done !== want_unit.string_done)
            report_mismatch("string_done", out_data.string_done, want_unit.string_done);
        end
      end

      // one long hold so the input side fills and stalls
      if (!held && n_results >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          pop_mode  = pop_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        phase++;
        case (pop_mode)
          POP_ALL:    out_pop <= 1'b1;
          POP_COIN:   out_pop <= 1'($urandom_range(0, 1));
          POP_EVERY3: out_pop <= (phase % 3 == 0);
          default:    out_pop <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    clear_decoder();

    // single-byte extremes and bad leads
    dir_tab[0]  = mk_row(8'h00, 1'b1, 1'b1, mk_res(16'h0000, 1'b1, 1'b0, 1'b1));
    dir_tab[1]  = mk_row(8'h7F, 1'b1, 1'b1, mk_res(16'h007F, 1'b1, 1'b0, 1'b1));
    dir_tab[2]  = mk_row(8'h80, 1'b1, 1'b1, mk_res(16'h0000, 1'b0, 1'b1, 1'b1));
    dir_tab[3]  = mk_row(8'hFF, 1'b1, 1'b1, mk_res(16'h0000, 1'b0, 1'b1, 1'b1));
    dir_tab[4]  = mk_row(8'hF8, 1'b1, 1'b1, mk_res(16'h0000, 1'b0, 1'b1, 1'b1));
    // leading BOM dropped, string ends with no unit
    dir_tab[5]  = mk_row(8'hEF, 1'b0, 1'b0, '0);
    dir_tab[6]  = mk_row(8'hBB, 1'b0, 1'b0, '0);
    dir_tab[7]  = mk_row(8'hBF, 1'b1, 1'b1, mk_res(16'h0000, 1'b0, 1'b0, 1'b1));
    // BOM later in the string is a normal unit
    dir_tab[8]  = mk_row(8'h41, 1'b0, 1'b0, '0);
    dir_tab[9]  = mk_row(8'hEF, 1'b0, 1'b0, '0);
    dir_tab[10] = mk_row(8'hBB, 1'b0, 1'b0, '0);
    dir_tab[11] = mk_row(8'hBF, 1'b1, 1'b0, '0);
    // U+10FFFF, top surrogate pair
    dir_tab[12] = mk_row(8'hF4, 1'b0, 1'b0, '0);
    dir_tab[13] = mk_row(8'h8F, 1'b0, 1'b0, '0);
    dir_tab[14] = mk_row(8'hBF, 1'b0, 1'b0, '0);
    dir_tab[15] = mk_row(8'hBF, 1'b1, 1'b0, '0);
    // above U+10FFFF
    dir_tab[16] = mk_row(8'hF4, 1'b0, 1'b0, '0);
    dir_tab[17] = mk_row(8'h90, 1'b0, 1'b0, '0);
    dir_tab[18] = mk_row(8'h80, 1'b0, 1'b0, '0);
    dir_tab[19] = mk_row(8'h80, 1'b1, 1'b1, mk_res(16'h0000, 1'b0, 1'b1, 1'b1));
    // truncated two-byte sequence
    dir_tab[20] = mk_row(8'hC3, 1'b1, 1'b1, mk_res(16'h0000, 1'b0, 1'b1, 1'b1));
    // bad continuation, rest of string swallowed
    dir_tab[21] = mk_row(8'hE2, 1'b0, 1'b0, '0);
    dir_tab[22] = mk_row(8'h41, 1'b0, 1'b0, '0);
    dir_tab[23] = mk_row(8'h42, 1'b1, 1'b1, mk_res(16'h0000, 1'b0, 1'b1, 1'b1));

    foreach (dir_tab[i]) stim_q.push_back(dir_tab[i]);
    while (n_rand < RAND_BYTES) gen_string();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || in_push) @(posedge clk);
    while (unit_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d bytes in %0d strings (%0d malformed), %0d results, %0d units",
             n_bytes, n_strings, n_bad_str, n_results, n_units);
    $display("output held %0d cycles once; input stalled on full for %0d cycles",
             HOLD_LEN, n_full_stall);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
src/u8u16_pkg.sv
src/u8u16_front.sv
src/u8u16_fifo.sv
src/u8u16_back.sv
src/utf8_to_utf16_decoder.sv
sim/tb_utf8_to_utf16_decoder.sv
